// File: design/ssd_pkg.sv
// Package for the segment-to-segment distance pipeline.
// Holds stream field widths, parameter defaults and the output limit.
// No dependencies.
package ssd_pkg;

  localparam int FIELD_W = 16;
  localparam int N_IN_FIELDS = 8;
  localparam int IN_DATA_W = FIELD_W * N_IN_FIELDS;
  localparam int OUT_W = 33;
  localparam int OUT_DATA_W = 40;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

endpackage

// File: design/ssd_point_seg.sv
// Six-stage pipeline that forms the scaled squared distance of a point to a
// segment as a dividend and divisor pair; their ratio is the exact value.
// Standalone; fed and drained by segment_segment_distance.
module ssd_point_seg #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16,
  localparam int PW = COORD_BITS + 1,
  localparam int CA = 2 * COORD_BITS + 4,
  localparam int NW = 2 * CA + 2 * FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [PW-1:0] px_i,
  input  logic signed [PW-1:0] py_i,
  input  logic signed [PW-1:0] ax_i,
  input  logic signed [PW-1:0] ay_i,
  input  logic signed [PW-1:0] bx_i,
  input  logic signed [PW-1:0] by_i,
  output logic [NW-1:0]        num_o,
  output logic [CA-1:0]        den_o
);

  localparam int DW  = PW + 1;
  localparam int PRW = 2 * DW;
  localparam int SW  = CA + 1;
  localparam int H   = CA / 2;
  localparam int HI  = CA - H;

  // Stage 1: differences.
  logic signed [DW-1:0] dx_q, dy_q, wx_q, wy_q, ex_q, ey_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= DW'(bx_i) - DW'(ax_i);
      dy_q <= DW'(by_i) - DW'(ay_i);
      wx_q <= DW'(px_i) - DW'(ax_i);
      wy_q <= DW'(py_i) - DW'(ay_i);
      ex_q <= DW'(px_i) - DW'(bx_i);
      ey_q <= DW'(py_i) - DW'(by_i);
    end
  end

  // Stage 2: products.
  logic signed [PRW-1:0] dxx_q, dyy_q, wxdx_q, wydy_q, wxdy_q, wydx_q;
  logic signed [PRW-1:0] wxx_q, wyy_q, exx_q, eyy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dxx_q  <= PRW'(dx_q) * PRW'(dx_q);
      dyy_q  <= PRW'(dy_q) * PRW'(dy_q);
      wxdx_q <= PRW'(wx_q) * PRW'(dx_q);
      wydy_q <= PRW'(wy_q) * PRW'(dy_q);
      wxdy_q <= PRW'(wx_q) * PRW'(dy_q);
      wydx_q <= PRW'(wy_q) * PRW'(dx_q);
      wxx_q  <= PRW'(wx_q) * PRW'(wx_q);
      wyy_q  <= PRW'(wy_q) * PRW'(wy_q);
      exx_q  <= PRW'(ex_q) * PRW'(ex_q);
      eyy_q  <= PRW'(ey_q) * PRW'(ey_q);
    end
  end

  // Stage 3: sums.
  logic signed [SW-1:0] len2_q, t_q, c_q, wsq_q, esq_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len2_q <= SW'(dxx_q) + SW'(dyy_q);
      t_q    <= SW'(wxdx_q) + SW'(wydy_q);
      c_q    <= SW'(wxdy_q) - SW'(wydx_q);
      wsq_q  <= SW'(wxx_q) + SW'(wyy_q);
      esq_q  <= SW'(exx_q) + SW'(eyy_q);
    end
  end

  // Stage 4: pick the nearest feature. A zero-length segment always has
  // t equal to zero and so falls to the start point.
  logic          t_le0, t_ge_len;
  logic          cr_d, cr_q;
  logic [CA-1:0] cabs_d, cabs_q, simple_d, simple_q, den_d, den_q;

  always_comb begin
    t_le0    = t_q[SW-1] || (t_q == '0);
    t_ge_len = (t_q >= len2_q);
    cr_d     = !t_le0 && !t_ge_len;
    cabs_d   = c_q[SW-1] ? CA'(-c_q) : CA'(c_q);
    simple_d = t_le0 ? wsq_q[CA-1:0] : esq_q[CA-1:0];
    den_d    = cr_d ? len2_q[CA-1:0] : CA'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cr_q     <= cr_d;
      cabs_q   <= cabs_d;
      simple_q <= simple_d;
      den_q    <= den_d;
    end
  end

  // Stage 5: the cross product is squared in half-width pieces.
  logic [2*HI-1:0]   hh_q;
  logic [HI+H-1:0]   hl_q;
  logic [2*H-1:0]    ll_q;
  logic              cr5_q;
  logic [CA-1:0]     simple5_q, den5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q      <= (2*HI)'(cabs_q[CA-1:H]) * (2*HI)'(cabs_q[CA-1:H]);
      hl_q      <= (HI+H)'(cabs_q[CA-1:H]) * (HI+H)'(cabs_q[H-1:0]);
      ll_q      <= (2*H)'(cabs_q[H-1:0]) * (2*H)'(cabs_q[H-1:0]);
      cr5_q     <= cr_q;
      simple5_q <= simple_q;
      den5_q    <= den_q;
    end
  end

  // Stage 6: assemble the scaled dividend.
  logic [NW-1:0] num_d, num_q;
  logic [CA-1:0] den6_q;

  always_comb begin
    if (cr5_q) begin
      num_d = (NW'(hh_q) << (2*H + 2*FRAC_BITS))
            + (NW'(hl_q) << (H + 1 + 2*FRAC_BITS))
            + (NW'(ll_q) << (2*FRAC_BITS));
    end else begin
      num_d = NW'(simple5_q) << (2*FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      den6_q <= den5_q;
    end
  end

  assign num_o = num_q;
  assign den_o = den6_q;

endmodule

// File: design/ssd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// The upper dividend bits must already be below the divisor. Standalone.
module ssd_div #(
  parameter int NW = 104,
  parameter int QW = 68,
  localparam int L = NW - QW
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [L-1:0]  den_i,
  output logic [QW-1:0] quo_o
);

  logic [L-1:0]  rem_q [QW-1];
  logic [L-1:0]  den_q [QW-1];
  // Holds the dividend bits still to come, with quotient bits shifted in.
  logic [QW-1:0] x_q   [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [L-1:0]  r_in, d_in;
    logic [QW-1:0] x_in;
    logic [L:0]    ext, diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign r_in = num_i[NW-1:QW];
      assign d_in = den_i;
      assign x_in = num_i[QW-1:0];
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign d_in = den_q[s-1];
      assign x_in = x_q[s-1];
    end

    assign ext  = {r_in, x_in[QW-1]};
    assign ge   = (ext >= {1'b0, d_in});
    assign diff = ge ? (ext - {1'b0, d_in}) : ext;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s] <= {x_in[QW-2:0], ge};
      end
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= diff[L-1:0];
          den_q[s] <= d_in;
        end
      end
    end
  end

  assign quo_o = x_q[QW-1];

endmodule

// File: design/ssd_sqrt.sv
// Pipelined integer square root, one root bit per stage (floor of the root).
// Standalone.
module ssd_sqrt #(
  parameter int RW = 34
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW-1:0]   root_o
);

  localparam int RMW = RW + 2;

  logic [RW-1:0]   root_q [RW];
  logic [RMW-1:0]  rem_q  [RW-1];
  logic [2*RW-1:0] rad_q  [RW-1];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW-1:0]    root_in;
    logic [RMW-1:0]   rem_in;
    logic [2*RW-1:0]  rad_in;
    logic [RMW+1:0]   ext, trial, rem_n;
    logic             ge;

    if (s == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign root_in = root_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    assign ext   = {rem_in, rad_in[2*RW-1:2*RW-2]};
    assign trial = (RMW+2)'({root_in, 2'b01});
    assign ge    = (ext >= trial);
    assign rem_n = ge ? (ext - trial) : ext;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[s] <= {root_in[RW-2:0], ge};
      end
    end

    if (s < RW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_n[RMW-1:0];
          rad_q[s] <= rad_in << 2;
        end
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// File: design/ssd_meet.sv
// Four-stage crossing and touching test for two segments using orientation
// signs and bounding-box checks. Standalone.
module ssd_meet #(
  parameter int COORD_BITS = 16,
  localparam int PW = COORD_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [PW-1:0] ax_i,
  input  logic signed [PW-1:0] ay_i,
  input  logic signed [PW-1:0] bx_i,
  input  logic signed [PW-1:0] by_i,
  input  logic signed [PW-1:0] cx_i,
  input  logic signed [PW-1:0] cy_i,
  input  logic signed [PW-1:0] dx_i,
  input  logic signed [PW-1:0] dy_i,
  output logic                 meet_o
);

  localparam int DW  = PW + 1;
  localparam int PRW = 2 * DW;
  localparam int OW  = PRW + 1;

  function automatic logic in_box(input logic signed [PW-1:0] ux, uy, vx, vy, px, py);
    return (px >= ux || px >= vx) && (px <= ux || px <= vx) &&
           (py >= uy || py >= vy) && (py <= uy || py <= vy);
  endfunction

  // Stage 1: edge vectors and box tests.
  logic signed [DW-1:0] bax_q, bay_q, cax_q, cay_q, dax_q, day_q;
  logic signed [DW-1:0] dcx_q, dcy_q, acx_q, acy_q, bcx_q, bcy_q;
  logic [3:0]           box1_q, box2_q, box3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bax_q <= DW'(bx_i) - DW'(ax_i);
      bay_q <= DW'(by_i) - DW'(ay_i);
      cax_q <= DW'(cx_i) - DW'(ax_i);
      cay_q <= DW'(cy_i) - DW'(ay_i);
      dax_q <= DW'(dx_i) - DW'(ax_i);
      day_q <= DW'(dy_i) - DW'(ay_i);
      dcx_q <= DW'(dx_i) - DW'(cx_i);
      dcy_q <= DW'(dy_i) - DW'(cy_i);
      acx_q <= DW'(ax_i) - DW'(cx_i);
      acy_q <= DW'(ay_i) - DW'(cy_i);
      bcx_q <= DW'(bx_i) - DW'(cx_i);
      bcy_q <= DW'(by_i) - DW'(cy_i);
      box1_q[0] <= in_box(ax_i, ay_i, bx_i, by_i, cx_i, cy_i);
      box1_q[1] <= in_box(ax_i, ay_i, bx_i, by_i, dx_i, dy_i);
      box1_q[2] <= in_box(cx_i, cy_i, dx_i, dy_i, ax_i, ay_i);
      box1_q[3] <= in_box(cx_i, cy_i, dx_i, dy_i, bx_i, by_i);
    end
  end

  // Stage 2: cross-product terms.
  logic signed [PRW-1:0] p_q [8];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= PRW'(bax_q) * PRW'(cay_q);
      p_q[1] <= PRW'(bay_q) * PRW'(cax_q);
      p_q[2] <= PRW'(bax_q) * PRW'(day_q);
      p_q[3] <= PRW'(bay_q) * PRW'(dax_q);
      p_q[4] <= PRW'(dcx_q) * PRW'(acy_q);
      p_q[5] <= PRW'(dcy_q) * PRW'(acx_q);
      p_q[6] <= PRW'(dcx_q) * PRW'(bcy_q);
      p_q[7] <= PRW'(dcy_q) * PRW'(bcx_q);
      box2_q <= box1_q;
    end
  end

  // Stage 3: orientation signs.
  logic [3:0] pos_q, neg_q;

  for (genvar k = 0; k < 4; k++) begin : g_orient
    logic signed [OW-1:0] o;
    assign o = OW'(p_q[2*k]) - OW'(p_q[2*k+1]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pos_q[k] <= !o[OW-1] && (o != '0);
        neg_q[k] <= o[OW-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      box3_q <= box2_q;
    end
  end

  // Stage 4: proper crossing, or an endpoint lying on the other segment.
  logic [3:0] zero;
  logic       straddle_ab, straddle_cd, meet_q;

  assign zero        = ~(pos_q | neg_q);
  assign straddle_ab = (pos_q[0] && neg_q[1]) || (neg_q[0] && pos_q[1]);
  assign straddle_cd = (pos_q[2] && neg_q[3]) || (neg_q[2] && pos_q[3]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meet_q <= (straddle_ab && straddle_cd) || (|(zero & box3_q));
    end
  end

  assign meet_o = meet_q;

endmodule

// File: design/segment_segment_distance.sv
// Minimum distance between two 2D segments, one request per cycle.
// Most pipeline stages lie in the one-bit-per-stage divider and square root.
// Throughput: one request per cycle; a stalled output holds the pipeline.
// Reset clears all valid bits, the output valid flag included; data needs no reset.
module segment_segment_distance
  import ssd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y (16 bits each)
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // min_distance [32:0], zero fill above
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // segments_meet
  output logic                  m_axis_tuser
);

  localparam int PW    = COORD_BITS + 1;
  localparam int CA    = 2 * COORD_BITS + 4;
  localparam int NW    = 2 * CA + 2 * FRAC_BITS;
  localparam int QW    = CA + 2 * FRAC_BITS;
  localparam int RW    = QW / 2;
  localparam int P     = 6 + QW + 2 + RW;
  localparam int MLAT  = 4;
  localparam int RWX   = (RW > OUT_W) ? RW : OUT_W;

  // Coordinates, sign-extended from the configured width when it fits a field, else zero-extended.
  logic signed [PW-1:0] crd [N_IN_FIELDS];

  for (genvar k = 0; k < N_IN_FIELDS; k++) begin : g_crd
    logic [FIELD_W-1:0] f;
    assign f = s_axis_tdata[FIELD_W*k +: FIELD_W];
    if (COORD_BITS <= FIELD_W) begin : g_narrow
      assign crd[k] = PW'($signed(f[COORD_BITS-1:0]));
    end else begin : g_wide
      assign crd[k] = PW'($signed({1'b0, f}));
    end
  end

  logic [P-1:0] vld_q;
  logic         en, accept, out_valid_q;

  // The pipeline moves unless its last stage holds a result the output
  // register cannot take.
  assign en            = !vld_q[P-1] || !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[P-2:0], accept};
    end
  end

  // Four endpoint-to-segment candidates: C and D to AB, A and B to CD.
  logic [NW-1:0] num [4];
  logic [CA-1:0] den [4];
  logic [QW-1:0] quo [4];

  ssd_point_seg #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_ps_c (
    .clk_i, .en_i(en),
    .px_i(crd[4]), .py_i(crd[5]), .ax_i(crd[0]), .ay_i(crd[1]),
    .bx_i(crd[2]), .by_i(crd[3]), .num_o(num[0]), .den_o(den[0])
  );
  ssd_point_seg #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_ps_d (
    .clk_i, .en_i(en),
    .px_i(crd[6]), .py_i(crd[7]), .ax_i(crd[0]), .ay_i(crd[1]),
    .bx_i(crd[2]), .by_i(crd[3]), .num_o(num[1]), .den_o(den[1])
  );
  ssd_point_seg #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_ps_a (
    .clk_i, .en_i(en),
    .px_i(crd[0]), .py_i(crd[1]), .ax_i(crd[4]), .ay_i(crd[5]),
    .bx_i(crd[6]), .by_i(crd[7]), .num_o(num[2]), .den_o(den[2])
  );
  ssd_point_seg #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_ps_b (
    .clk_i, .en_i(en),
    .px_i(crd[2]), .py_i(crd[3]), .ax_i(crd[4]), .ay_i(crd[5]),
    .bx_i(crd[6]), .by_i(crd[7]), .num_o(num[3]), .den_o(den[3])
  );

  for (genvar k = 0; k < 4; k++) begin : g_div
    ssd_div #(.NW(NW), .QW(QW)) u_div (
      .clk_i, .en_i(en), .num_i(num[k]), .den_i(den[k]), .quo_o(quo[k])
    );
  end

  // Two-level registered minimum.
  logic [QW-1:0] min01_q, min23_q, min_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      min01_q <= (quo[1] < quo[0]) ? quo[1] : quo[0];
      min23_q <= (quo[3] < quo[2]) ? quo[3] : quo[2];
      min_q   <= (min23_q < min01_q) ? min23_q : min01_q;
    end
  end

  logic [RW-1:0] root;

  ssd_sqrt #(.RW(RW)) u_sqrt (
    .clk_i, .en_i(en), .rad_i(min_q), .root_o(root)
  );

  // The meet flag rides alongside the distance pipeline.
  logic meet;
  logic meet_dly_q [P-MLAT];

  ssd_meet #(.COORD_BITS(COORD_BITS)) u_meet (
    .clk_i, .en_i(en),
    .ax_i(crd[0]), .ay_i(crd[1]), .bx_i(crd[2]), .by_i(crd[3]),
    .cx_i(crd[4]), .cy_i(crd[5]), .dx_i(crd[6]), .dy_i(crd[7]),
    .meet_o(meet)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      meet_dly_q[0] <= meet;
      for (int j = 1; j < P - MLAT; j++) begin
        meet_dly_q[j] <= meet_dly_q[j-1];
      end
    end
  end

  // Output register.
  logic [RWX-1:0]   root_x;
  logic [OUT_W-1:0] dist_d, dist_q;
  logic             meet_out_q, load;

  assign root_x = RWX'(root);
  assign load   = en && vld_q[P-1];

  always_comb begin
    if (meet_dly_q[P-MLAT-1]) begin
      dist_d = '0;
    end else if (root_x > RWX'(OUT_MAX)) begin
      dist_d = OUT_MAX;
    end else begin
      dist_d = root_x[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dist_q     <= dist_d;
      meet_out_q <= meet_dly_q[P-MLAT-1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(dist_q);
  assign m_axis_tuser  = meet_out_q;

`ifndef NO_ASSERTIONS
  a_meet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> dist_q == '0)
    else $error("meeting segments reported a nonzero distance");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[P-1] && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while the pipeline is blocked");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[P-1] |=> out_valid_q)
    else $error("finished result did not reach the output register");
`endif

endmodule
